[rtl/core/bpq_pkg.sv]
// ---------------------------------------------------------------------------
// bpq_pkg
// Shared types, field widths and helpers of the bitmap priority ready queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpq_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned PRIO_W = 8;

  typedef enum logic [KIND_W-1:0] {
    REQ_PUT     = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_REQUEUE = 2'd2,
    REQ_NONE    = 2'd3
  } req_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRD,
    ST_DLINK,
    ST_DFIX,
    ST_ENQ,
    ST_ELINK,
    ST_GRP,
    ST_HEAD,
    ST_OUT
  } bpq_state_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [4:0] lowest32(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

endpackage

[rtl/core/bpq_ram.sv]
// ---------------------------------------------------------------------------
// bpq_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bitmap_priority_ready_queue.sv]
// ---------------------------------------------------------------------------
// bitmap_priority_ready_queue
// Ready queue of a task scheduler: one fifo per priority level, linked in ram.
// ---------------------------------------------------------------------------
// Input channel (in_*): one request item per handshake: put, remove or requeue
// of a task. Output channel (out_*): exactly one result item per request,
// giving the head task of the lowest-numbered occupied level, none_ready
// when the queue is empty, and request_error for a rejected request.
// One request is worked on at a time, ending in the group search (GRP), head
// read (HEAD) and result (OUT) steps. Before them a valid put links the task
// in (ENQ, and ELINK for an occupied level), a valid remove unlinks it (DRD,
// DLINK, DFIX), and a requeue unlinks a queued task and links it in; each
// list step waits on the registered ram reads. The result register is filled
// in the last step; a new request is taken while the result still waits, and
// the block only holds in its last step while the previous result is stalled.
// Reset clears the occupancy bitmap and the queued bits; the rams need no
// clearing, since an entry is read only once written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_priority_ready_queue #(
  parameter int unsigned PRIORITY_LEVELS = 256,
  parameter int unsigned TASK_SLOTS      = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bpq_pkg::KIND_W-1:0] in_req_type,
  input  logic [bpq_pkg::SLOT_W-1:0] in_task_slot,
  input  logic [bpq_pkg::PRIO_W-1:0] in_task_priority,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bpq_pkg::SLOT_W-1:0] out_highest_task,
  output logic                       out_none_ready,
  output logic                       out_request_error
);
  import bpq_pkg::*;

  localparam int unsigned LW  = $clog2(PRIORITY_LEVELS);
  localparam int unsigned SIW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned NG  = (PRIORITY_LEVELS + 31) / 32;
  localparam int unsigned GIW = (NG > 1) ? $clog2(NG) : 1;

  bpq_state_t state_r, state_nxt;

  logic [SLOT_W-1:0] slot_r;
  logic [LW-1:0]     lvl_r;
  logic              err_r, enq_r;
  logic [LW-1:0]     dlvl_r;
  logic [SLOT_W-1:0] dprev_r, dnext_r;
  logic [GIW-1:0]    grp_r, grp_nxt;
  logic              none_r;

  logic [TASK_SLOTS-1:0] queued_r;
  logic [NG*32-1:0]      lbits_r;
  logic [NG-1:0]         gbits;

  logic              out_valid_r, out_none_r, out_err_r;
  logic [SLOT_W-1:0] out_task_r;

  // ram ports
  logic              hd_we, tl_we, nx_we, pv_we, lv_we;
  logic [LW-1:0]     hd_waddr, tl_waddr, hd_raddr, tl_raddr;
  logic [SLOT_W-1:0] hd_wdata, tl_wdata, nx_wdata, pv_wdata;
  logic [SLOT_W-1:0] hd_rdata, tl_rdata, nx_rdata, pv_rdata;
  logic [SIW-1:0]    nx_waddr, pv_waddr, slot_idx;
  logic [LW-1:0]     lv_rdata;

  logic              accept, in_range, q_hit;
  logic [LW-1:0]     in_lvl, best;
  logic [4:0]        low;
  logic              at_head, at_tail;
  logic              mark, unmark, set_q, clr_q, load_out;
  logic [31:0]       grp_word;

  assign slot_idx = SIW'(slot_r);
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign in_range = (32'(in_task_slot) < TASK_SLOTS);
  assign q_hit    = queued_r[SIW'(in_task_slot)];
  assign in_lvl   = (32'(in_task_priority) >= PRIORITY_LEVELS) ?
                    LW'(PRIORITY_LEVELS - 1) : LW'(in_task_priority);

  always_comb begin
    for (int g = 0; g < NG; g++) gbits[g] = |lbits_r[g*32 +: 32];
  end

  // lowest occupied group
  always_comb begin
    grp_nxt = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (gbits[g]) grp_nxt = GIW'(g);
    end
  end

  assign grp_word = lbits_r[32*grp_r +: 32];
  assign low      = lowest32(grp_word);
  assign best     = LW'({grp_r, low});
  assign at_head  = (hd_rdata == slot_r);
  assign at_tail  = (tl_rdata == slot_r);

  bpq_ram #(.WIDTH(SLOT_W), .DEPTH(PRIORITY_LEVELS)) u_head (
    .clk, .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
    .raddr(hd_raddr), .rdata(hd_rdata));
  bpq_ram #(.WIDTH(SLOT_W), .DEPTH(PRIORITY_LEVELS)) u_tail (
    .clk, .we(tl_we), .waddr(tl_waddr), .wdata(tl_wdata),
    .raddr(tl_raddr), .rdata(tl_rdata));
  bpq_ram #(.WIDTH(SLOT_W), .DEPTH(TASK_SLOTS)) u_next (
    .clk, .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(slot_idx), .rdata(nx_rdata));
  bpq_ram #(.WIDTH(SLOT_W), .DEPTH(TASK_SLOTS)) u_prev (
    .clk, .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(slot_idx), .rdata(pv_rdata));
  bpq_ram #(.WIDTH(LW), .DEPTH(TASK_SLOTS)) u_level (
    .clk, .we(lv_we), .waddr(slot_idx), .wdata(lvl_r),
    .raddr(slot_idx), .rdata(lv_rdata));

  always_comb begin
    state_nxt = state_r;
    hd_we = 1'b0; hd_waddr = lvl_r; hd_wdata = slot_r; hd_raddr = lv_rdata;
    tl_we = 1'b0; tl_waddr = lvl_r; tl_wdata = slot_r; tl_raddr = lv_rdata;
    nx_we = 1'b0; nx_waddr = SIW'(dprev_r); nx_wdata = dnext_r;
    pv_we = 1'b0; pv_waddr = SIW'(dnext_r); pv_wdata = dprev_r;
    lv_we = 1'b0;
    mark = 1'b0; unmark = 1'b0; set_q = 1'b0; clr_q = 1'b0; load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (!in_range && in_req_type != REQ_NONE) state_nxt = ST_GRP;
          else if (in_req_type == REQ_NONE) state_nxt = ST_GRP;
          else if (in_req_type == REQ_PUT) state_nxt = q_hit ? ST_GRP : ST_ENQ;
          else if (in_req_type == REQ_REMOVE) state_nxt = q_hit ? ST_DRD : ST_GRP;
          else state_nxt = q_hit ? ST_DRD : ST_ENQ;
        end
      end
      ST_DRD:   state_nxt = ST_DLINK;
      ST_DLINK: state_nxt = ST_DFIX;  // head and tail of the task's level read here
      ST_DFIX: begin
        hd_waddr = dlvl_r; tl_waddr = dlvl_r;
        clr_q = 1'b1;
        if (at_head && at_tail) begin
          unmark = 1'b1;
        end else begin
          if (at_head) begin
            hd_we = 1'b1; hd_wdata = dnext_r;
          end else begin
            nx_we = 1'b1;
          end
          if (at_tail) begin
            tl_we = 1'b1; tl_wdata = dprev_r;
          end else begin
            pv_we = 1'b1;
          end
        end
        state_nxt = enq_r ? ST_ENQ : ST_GRP;
      end
      ST_ENQ: begin
        tl_raddr = lvl_r;
        if (lbits_r[lvl_r]) begin
          state_nxt = ST_ELINK;
        end else begin
          hd_we = 1'b1; tl_we = 1'b1; lv_we = 1'b1;
          mark = 1'b1; set_q = 1'b1;
          state_nxt = ST_GRP;
        end
      end
      ST_ELINK: begin
        nx_we = 1'b1; nx_waddr = SIW'(tl_rdata); nx_wdata = slot_r;
        pv_we = 1'b1; pv_waddr = slot_idx; pv_wdata = tl_rdata;
        tl_we = 1'b1; lv_we = 1'b1; set_q = 1'b1;
        state_nxt = ST_GRP;
      end
      ST_GRP:  state_nxt = ST_HEAD;
      ST_HEAD: begin
        hd_raddr = best;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // keep the head read alive while the previous result is stalled
        hd_raddr = best;
        if (!out_valid_r || !out_stall) begin
          load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      queued_r    <= '0;
      lbits_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (set_q) queued_r[slot_idx] <= 1'b1;
      if (clr_q) queued_r[slot_idx] <= 1'b0;
      if (mark) lbits_r[lvl_r] <= 1'b1;
      if (unmark) lbits_r[dlvl_r] <= 1'b0;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r <= in_task_slot;
      lvl_r  <= in_lvl;
      err_r  <= in_req_type != REQ_NONE &&
                (!in_range || (in_req_type == REQ_PUT && q_hit) ||
                 (in_req_type == REQ_REMOVE && !q_hit));
      enq_r  <= (in_req_type == REQ_REQUEUE);
    end
    if (state_r == ST_DLINK) begin
      dlvl_r  <= lv_rdata;
      dprev_r <= pv_rdata;
      dnext_r <= nx_rdata;
    end
    if (state_r == ST_GRP) begin
      none_r <= (gbits == '0);
      grp_r  <= grp_nxt;
    end
    if (load_out) begin
      out_task_r <= none_r ? '0 : hd_rdata;
      out_none_r <= none_r;
      out_err_r  <= err_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_highest_task  = out_task_r;
  assign out_none_ready    = out_none_r;
  assign out_request_error = out_err_r;

endmodule
